@@ src/prq_pkg.sv @@
package prq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF    = 16;
   localparam int ID_BITS_DEF     = 8;

   localparam int TASK_ID_W  = 8;
   localparam int SORT_KEY_W = 16;
   localparam int OCC_W      = 5;
   localparam int POLICY_W   = 3;

   localparam logic [POLICY_W-1:0] FCFS             = 3'd0;
   localparam logic [POLICY_W-1:0] POL_SJF_PREEMPT  = 3'd1;
   localparam logic [POLICY_W-1:0] POL_SJF_KEEP     = 3'd2;
   localparam logic [POLICY_W-1:0] POL_PRIO_PREEMPT = 3'd3;
   localparam logic [POLICY_W-1:0] POL_PRIO_KEEP    = 3'd4;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [TASK_ID_W-1:0]  task_id;
      logic [SORT_KEY_W-1:0] sort_key;
   } req_type;

   typedef struct packed {
      logic                 head_valid;
      logic [TASK_ID_W-1:0] head_task;
      logic [OCC_W-1:0]     occupancy;
      logic                 head_changed;
      logic                 push_dropped;
   } rsp_type;

endpackage

@@ src/prq_store.sv @@
module prq_store #(
   parameter int DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
   parameter int WIDTH = prq_pkg::ID_BITS_DEF + prq_pkg::KEY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] entry_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/prq_cmp.sv @@
module prq_cmp #(
   parameter int KEY_BITS = prq_pkg::KEY_BITS_DEF
) (
   input  logic [prq_pkg::POLICY_W-1:0] policy,
   input  logic [KEY_BITS-1:0]          fresh_key,
   input  logic [KEY_BITS-1:0]          held_key,
   output logic                         goes_before
);

   logic smallest_first;

   always_comb begin
      smallest_first = policy inside {prq_pkg::POL_SJF_PREEMPT, prq_pkg::POL_SJF_KEEP};
      if (smallest_first) begin
         goes_before = fresh_key < held_key;
      end else begin
         goes_before = fresh_key > held_key;
      end
   end

endmodule

@@ src/prq_seq.sv @@
module prq_seq #(
   parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
   parameter int KEY_BITS    = prq_pkg::KEY_BITS_DEF,
   parameter int ID_BITS     = prq_pkg::ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         func,
   input  logic [ID_BITS-1:0]           start_id,
   input  logic [KEY_BITS-1:0]          start_key,
   input  logic [prq_pkg::POLICY_W-1:0] policy,
   output logic                         idle,
   output logic                         done,
   input  logic                         ack,
   output prq_pkg::rsp_type             result
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = ID_BITS + KEY_BITS;
   localparam int OW = prq_pkg::OCC_W;
   localparam int TW = prq_pkg::TASK_ID_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_SHIFT  = 6'b000100,
      S_PLACE  = 6'b001000,
      S_POP    = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic [AW-1:0]       src_ff, src_in;
   logic [AW-1:0]       wr_ff, wr_in;
   logic                pend_ff, pend_in;
   logic                last_ff, last_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [ID_BITS-1:0]  head_id_ff, head_id_in;
   logic [KEY_BITS-1:0] head_key_ff, head_key_in;
   logic                changed_ff, changed_in;
   logic                dropped_ff, dropped_in;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [EW-1:0]       rd_data;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [EW-1:0]       wr_data;
   logic [ID_BITS-1:0]  rd_id;
   logic [KEY_BITS-1:0] rd_key;
   logic [KEY_BITS-1:0] cmp_fresh;
   logic [KEY_BITS-1:0] cmp_held;
   logic                cmp_before;
   logic                preempt;

   prq_store #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   prq_cmp #(
      .KEY_BITS (KEY_BITS)
   ) u_cmp (
      .policy      (policy),
      .fresh_key   (cmp_fresh),
      .held_key    (cmp_held),
      .goes_before (cmp_before)
   );

   assign rd_id   = rd_data[EW-1:KEY_BITS];
   assign rd_key  = rd_data[KEY_BITS-1:0];
   assign preempt = policy inside {prq_pkg::POL_SJF_PREEMPT, prq_pkg::POL_PRIO_PREEMPT};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      slot_in     = slot_ff;
      src_in      = src_ff;
      wr_in       = wr_ff;
      pend_in     = pend_ff;
      last_in     = last_ff;
      id_in       = id_ff;
      key_in      = key_ff;
      head_id_in  = head_id_ff;
      head_key_in = head_key_ff;
      changed_in  = changed_ff;
      dropped_in  = dropped_ff;
      rd_en       = 1'b0;
      rd_addr     = AW'(1);
      wr_en       = 1'b0;
      wr_addr     = wr_ff;
      wr_data     = rd_data;
      cmp_fresh   = key_ff;
      cmp_held    = rd_key;
      case (state_ff)
         S_IDLE: begin
            rd_en     = 1'b1;
            rd_addr   = AW'(1);
            cmp_fresh = start_key;
            cmp_held  = head_key_ff;
            if (start) begin
               id_in      = start_id;
               key_in     = start_key;
               changed_in = 1'b0;
               dropped_in = 1'b0;
               pend_in    = 1'b0;
               last_in    = 1'b0;
               ptr_in     = AW'(1);
               src_in     = AW'(count_ff - CW'(1));
               if (func == prq_pkg::FUNC_POP) begin
                  if (count_ff == '0) begin
                     state_in = S_DONE;
                  end else if (count_ff == CW'(1)) begin
                     count_in   = '0;
                     changed_in = 1'b1;
                     state_in   = S_DONE;
                  end else begin
                     state_in = S_POP;
                  end
               end else if (policy > prq_pkg::POL_PRIO_KEEP) begin
                  state_in = S_DONE;
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  dropped_in = 1'b1;
                  state_in   = S_DONE;
               end else if ((policy == prq_pkg::FCFS) || (count_ff == '0)) begin
                  slot_in  = AW'(count_ff);
                  state_in = S_PLACE;
               end else if (preempt && cmp_before) begin
                  slot_in  = '0;
                  state_in = S_SHIFT;
               end else if (count_ff == CW'(1)) begin
                  slot_in  = AW'(1);
                  state_in = S_PLACE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff + AW'(1);
            if (cmp_before) begin
               slot_in  = ptr_ff;
               state_in = S_SHIFT;
            end else if ((CW'(ptr_ff) + CW'(1)) == count_ff) begin
               slot_in  = AW'(count_ff);
               state_in = S_PLACE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         S_SHIFT: begin
            wr_en   = pend_ff;
            wr_addr = wr_ff;
            wr_data = rd_data;
            if (last_ff) begin
               pend_in  = 1'b0;
               state_in = S_PLACE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = src_ff;
               pend_in = 1'b1;
               wr_in   = src_ff + AW'(1);
               last_in = (src_ff == slot_ff);
               src_in  = src_ff - AW'(1);
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = {id_ff, key_ff};
            count_in = count_ff + CW'(1);
            if (slot_ff == '0) begin
               head_id_in  = id_ff;
               head_key_in = key_ff;
               changed_in  = 1'b1;
            end
            state_in = S_DONE;
         end
         S_POP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - AW'(1);
            wr_data = rd_data;
            if (ptr_ff == AW'(1)) begin
               head_id_in  = rd_id;
               head_key_in = rd_key;
            end
            if ((CW'(ptr_ff) + CW'(1)) == count_ff) begin
               count_in   = count_ff - CW'(1);
               changed_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AW'(1);
               ptr_in  = ptr_ff + AW'(1);
            end
         end
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      ptr_ff      <= ptr_in;
      slot_ff     <= slot_in;
      src_ff      <= src_in;
      wr_ff       <= wr_in;
      pend_ff     <= pend_in;
      last_ff     <= last_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      head_id_ff  <= head_id_in;
      head_key_ff <= head_key_in;
      changed_ff  <= changed_in;
      dropped_ff  <= dropped_in;
   end

   always_comb begin
      idle                = (state_ff == S_IDLE);
      done                = (state_ff == S_DONE);
      result.head_valid   = (count_ff != '0);
      result.head_task    = (count_ff != '0) ? TW'(head_id_ff) : '0;
      result.occupancy    = OW'(count_ff);
      result.head_changed = changed_ff;
      result.push_dropped = dropped_ff;
   end

   a_place_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLACE) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("place did not grow the queue by one");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && dropped_ff) |-> (count_ff == CW'(QUEUE_DEPTH)))
      else $error("push dropped while queue not full");

   a_shift_not_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && pend_ff) |-> (wr_ff != '0))
      else $error("shift wrote into the head entry");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == S_IDLE))
      else $error("transaction started while busy");

endmodule

@@ src/policy_ready_queue.sv @@
// Ready queue of tasks for a CPU scheduler, ordered by the policy in the csr register.
// Request channel (req_valid, req_stall, req_data): a push (func 0) inserts task_id with
// sort_key, a pop (func 1) removes the head task. One response per request on the rsp
// channel gives the head task, occupancy and the head_changed / push_dropped flags.
// csr_write_en with csr_write_data sets the policy; write it only while no transaction is
// in flight.
// A push into a full queue is dropped and a push under an unused policy is ignored; both
// go straight to the response, as does a pop with at most one entry. FCFS pushes, and
// pushes into an empty queue or behind a single entry, write their slot directly. A sorted
// push searches from the second entry toward the tail; if it lands ahead of the tail or
// preempts the head, the entries from its slot on are shifted up first. A pop with two or
// more entries moves every other entry down by one. The sequencer walks the entry memory
// one entry per cycle; it takes the next request once the response is in the output register.
// req_stall is high while a transaction is in flight; one transaction at a time.
// The response sits in an output register; a stalled response holds, and the next
// response waits in the sequencer until the register is free.
// Synchronous reset empties the queue and sets the policy to FCFS; no clearing pass.
module policy_ready_queue #(
   parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
   parameter int KEY_BITS    = prq_pkg::KEY_BITS_DEF,
   parameter int ID_BITS     = prq_pkg::ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  prq_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output prq_pkg::rsp_type             rsp_data,
   input  logic                         csr_write_en,
   input  logic [prq_pkg::POLICY_W-1:0] csr_write_data
);

   logic [prq_pkg::POLICY_W-1:0] policy_ff, policy_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   prq_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic                         seq_idle;
   logic                         seq_done;
   logic                         start;
   logic                         ack;
   prq_pkg::rsp_type             seq_result;

   assign req_stall = !seq_idle;
   assign start     = req_valid && !req_stall;
   assign ack       = !rsp_valid_ff || !rsp_stall;

   prq_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .ID_BITS     (ID_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .func      (req_data.func),
      .start_id  (ID_BITS'(req_data.task_id)),
      .start_key (KEY_BITS'(req_data.sort_key)),
      .policy    (policy_ff),
      .idle      (seq_idle),
      .done      (seq_done),
      .ack       (ack),
      .result    (seq_result)
   );

   always_comb begin
      policy_in    = csr_write_en ? csr_write_data : policy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_done && ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= prq_pkg::FCFS;
         rsp_valid_ff <= 1'b0;
      end else begin
         policy_ff    <= policy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ verif/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 2 * prq_pkg::QUEUE_DEPTH_DEF + 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASES        = 12;

   localparam logic [prq_pkg::POLICY_W-1:0] UNUSED_POLICY_LO  = 3'd5;
   localparam logic [prq_pkg::POLICY_W-1:0] UNUSED_POLICY_MID = 3'd6;
   localparam logic [prq_pkg::POLICY_W-1:0] UNUSED_POLICY_HI  = 3'd7;

   localparam prq_pkg::req_type NO_ITEM = '0;
   localparam prq_pkg::rsp_type NO_WANT = '0;

   typedef enum logic {ROW_ITEM, ROW_POLICY} row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      logic [prq_pkg::POLICY_W-1:0] policy;
      prq_pkg::req_type             item;
      logic [4:0]                   reps;
      logic                         typed;
      prq_pkg::rsp_type             want;
   } stim_row_type;

   logic                         clock;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   prq_pkg::req_type             req_data       = '0;
   logic                         rsp_stall      = 1'b0;
   logic                         csr_write_en   = 1'b0;
   logic [prq_pkg::POLICY_W-1:0] csr_write_data = '0;
   logic                         req_stall;
   logic                         rsp_valid;
   prq_pkg::rsp_type             rsp_data;

   stim_row_type directed_rows [0:23] = '{
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_POP, 8'h5A, 16'hA5A5}, 5'd1, 1'b1,
        '{1'b0, 8'h00, 5'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'hFF, 16'hFFFF}, 5'd1, 1'b1,
        '{1'b1, 8'hFF, 5'd1, 1'b1, 1'b0}},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h00, 16'h0000}, 5'd1, 1'b1,
        '{1'b1, 8'hFF, 5'd2, 1'b0, 1'b0}},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_POP, 8'hA5, 16'h5A5A}, 5'd1, 1'b1,
        '{1'b1, 8'h00, 5'd1, 1'b1, 1'b0}},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_POP, 8'h00, 16'h0000}, 5'd1, 1'b1,
        '{1'b0, 8'h00, 5'd0, 1'b1, 1'b0}},
      '{ROW_POLICY, prq_pkg::POL_SJF_PREEMPT, NO_ITEM, 5'd0, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h01, 16'd100}, 5'd1, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h02, 16'd50}, 5'd1, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h03, 16'd50}, 5'd1, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h04, 16'hFFFF}, 5'd1, 1'b0, NO_WANT},
      '{ROW_POLICY, prq_pkg::POL_SJF_KEEP, NO_ITEM, 5'd0, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h05, 16'h0000}, 5'd1, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_POP, 8'h00, 16'h0000}, 5'd1, 1'b0, NO_WANT},
      '{ROW_POLICY, prq_pkg::POL_PRIO_PREEMPT, NO_ITEM, 5'd0, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h06, 16'hFFFF}, 5'd1, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h07, 16'hFFFF}, 5'd1, 1'b0, NO_WANT},
      '{ROW_POLICY, prq_pkg::POL_PRIO_KEEP, NO_ITEM, 5'd0, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h08, 16'hFFFF}, 5'd1, 1'b0, NO_WANT},
      '{ROW_POLICY, UNUSED_POLICY_HI, NO_ITEM, 5'd0, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h09, 16'h0001}, 5'd1, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_POP, 8'hFF, 16'hFFFF}, 5'd1, 1'b0, NO_WANT},
      '{ROW_POLICY, prq_pkg::FCFS, NO_ITEM, 5'd0, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h0A, 16'h0000}, 5'd10, 1'b0, NO_WANT},
      '{ROW_ITEM, prq_pkg::FCFS, '{prq_pkg::FUNC_PUSH, 8'h0B, 16'hFFFF}, 5'd1, 1'b0, NO_WANT}
   };

   logic [prq_pkg::POLICY_W-1:0] phase_policies [0:PHASES-1] = '{
      prq_pkg::FCFS, prq_pkg::POL_SJF_PREEMPT, prq_pkg::POL_SJF_KEEP,
      prq_pkg::POL_PRIO_PREEMPT, prq_pkg::POL_PRIO_KEEP, UNUSED_POLICY_HI,
      prq_pkg::POL_SJF_PREEMPT, prq_pkg::POL_PRIO_PREEMPT, prq_pkg::POL_SJF_KEEP,
      prq_pkg::POL_PRIO_KEEP, UNUSED_POLICY_LO, UNUSED_POLICY_MID
   };

   logic [prq_pkg::TASK_ID_W-1:0]  sched_ids  [prq_pkg::QUEUE_DEPTH_DEF];
   logic [prq_pkg::SORT_KEY_W-1:0] sched_keys [prq_pkg::QUEUE_DEPTH_DEF];
   int                             sched_count  = 0;
   logic [prq_pkg::POLICY_W-1:0]   sched_policy = prq_pkg::FCFS;

   prq_pkg::rsp_type due_head_reports [$];
   int      mismatch_count = 0;
   int      send_idle_pct  = 22;
   int      recv_idle_pct  = 77;
   int      idle_cycles    = 0;
   int      hold_left      = 0;
   logic [7:0] hold_ticket = '0;
   logic [7:0] hold_seen   = '0;

   policy_ready_queue dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic key_ahead(logic [prq_pkg::SORT_KEY_W-1:0] fresh,
                                      logic [prq_pkg::SORT_KEY_W-1:0] held,
                                      logic smallest_first);
      return smallest_first ? (fresh < held) : (fresh > held);
   endfunction

   function automatic prq_pkg::rsp_type ready_queue_step(prq_pkg::req_type t);
      prq_pkg::rsp_type r;
      int      slot;
      int      i;
      logic    changed;
      logic    dropped;
      logic    smallest_first;
      logic    preempt;
      changed = 1'b0;
      dropped = 1'b0;
      if (t.func == prq_pkg::FUNC_POP) begin
         if (sched_count > 0) begin
            for (i = 1; i < sched_count; i++) begin
               sched_ids[i-1]  = sched_ids[i];
               sched_keys[i-1] = sched_keys[i];
            end
            sched_count--;
            changed = 1'b1;
         end
      end else if (sched_policy <= prq_pkg::POL_PRIO_KEEP) begin
         if (sched_count >= prq_pkg::QUEUE_DEPTH_DEF) begin
            dropped = 1'b1;
         end else begin
            smallest_first = sched_policy inside
               {prq_pkg::POL_SJF_PREEMPT, prq_pkg::POL_SJF_KEEP};
            preempt = sched_policy inside
               {prq_pkg::POL_SJF_PREEMPT, prq_pkg::POL_PRIO_PREEMPT};
            slot = sched_count;
            if (sched_policy != prq_pkg::FCFS && sched_count != 0) begin
               if (preempt && key_ahead(t.sort_key, sched_keys[0], smallest_first)) begin
                  slot = 0;
               end else begin
                  // scan downward so the lowest qualifying slot wins
                  for (i = sched_count - 1; i >= 1; i--) begin
                     if (key_ahead(t.sort_key, sched_keys[i], smallest_first)) slot = i;
                  end
               end
            end
            for (i = sched_count; i > slot; i--) begin
               sched_ids[i]  = sched_ids[i-1];
               sched_keys[i] = sched_keys[i-1];
            end
            sched_ids[slot]  = t.task_id;
            sched_keys[slot] = t.sort_key;
            sched_count++;
            if (slot == 0) changed = 1'b1;
         end
      end
      r.head_valid   = (sched_count > 0);
      r.head_task    = (sched_count > 0) ? sched_ids[0] : '0;
      r.occupancy    = sched_count[prq_pkg::OCC_W-1:0];
      r.head_changed = changed;
      r.push_dropped = dropped;
      return r;
   endfunction

   task automatic send_transaction(input prq_pkg::req_type t, input logic typed,
                                   input prq_pkg::rsp_type want);
      prq_pkg::rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = ready_queue_step(t);
      due_head_reports.push_back(typed ? want : predicted);
   endtask

   task automatic wait_for_heads();
      req_valid <= 1'b0;
      while (due_head_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_policy(input logic [prq_pkg::POLICY_W-1:0] value);
      wait_for_heads();
      repeat (2) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sched_policy = value;
   endtask

   task automatic check_head_report(input prq_pkg::rsp_type got);
      prq_pkg::rsp_type want;
      if (due_head_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected transaction: valid=%0d task=%0d occ=%0d changed=%0d dropped=%0d",
                     got.head_valid, got.head_task, got.occupancy, got.head_changed,
                     got.push_dropped);
      end else begin
         want = due_head_reports.pop_front();
         if (got.head_valid !== want.head_valid || got.head_task !== want.head_task ||
             got.occupancy !== want.occupancy || got.head_changed !== want.head_changed ||
             got.push_dropped !== want.push_dropped) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("mismatch: expected valid=%0d task=%0d occ=%0d changed=%0d dropped=%0d",
                        want.head_valid, want.head_task, want.occupancy, want.head_changed,
                        want.push_dropped);
               $display("          actual   valid=%0d task=%0d occ=%0d changed=%0d dropped=%0d",
                        got.head_valid, got.head_task, got.occupancy, got.head_changed,
                        got.push_dropped);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_head_report(rsp_data);
         if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      prq_pkg::req_type item;
      int      r;
      int      k;
      int      phase;
      int      n_items;
      int      pop_pct;
      pop_pct = 50;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < $size(directed_rows); r++) begin
         if (directed_rows[r].kind == ROW_POLICY) begin
            write_policy(directed_rows[r].policy);
         end else begin
            for (k = 0; k < directed_rows[r].reps; k++)
               send_transaction(directed_rows[r].item, directed_rows[r].typed,
                                directed_rows[r].want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 4) begin
            send_idle_pct = 77;
            recv_idle_pct = 22;
         end else if (phase == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_policy(phase_policies[phase]);
         n_items = (phase_policies[phase] > prq_pkg::POL_PRIO_KEEP) ? 30 : 115;
         for (k = 0; k < n_items; k++) begin
            // swing occupancy between empty and full
            if (k % 24 == 0) begin
               case ($urandom_range(0, 2))
                  0: begin
                     pop_pct = 15;
                  end
                  1: begin
                     pop_pct = 50;
                  end
                  default: begin
                     pop_pct = 85;
                  end
               endcase
            end
            if (phase == 2 && k == 40) hold_ticket <= hold_ticket + 8'd1;
            if (phase == 9 && k == 50) wait_for_heads();
            item.func    = ($urandom_range(0, 99) < pop_pct) ? prq_pkg::FUNC_POP
                                                             : prq_pkg::FUNC_PUSH;
            item.task_id = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
               0: begin
                  item.sort_key = 16'($urandom_range(0, 3));
               end
               1: begin
                  item.sort_key = $urandom_range(0, 1) ? '1 : '0;
               end
               default: begin
                  item.sort_key = 16'($urandom_range(0, 65535));
               end
            endcase
            send_transaction(item, 1'b0, NO_WANT);
         end
      end

      wait_for_heads();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_head_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/prq_pkg.sv
src/prq_store.sv
src/prq_cmp.sv
src/prq_seq.sv
src/policy_ready_queue.sv
verif/testbench.sv
